// ----- hw/rtl/vtce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtce_pkg: shared types and constants of the vector terminal encoder
// Beat structs, command codes, stream byte codes and the scaling constants.
// ----------------------------------------------------------------------------
package vtce_pkg;

   localparam int unsigned CoordWidth = 12;   // plot coordinate width
   localparam int unsigned TermXWidth = 11;   // scaled x / pen x width
   localparam int unsigned TermYWidth = 10;   // scaled y / pen y width
   localparam int unsigned IdxWidth   = 5;    // byte index within a command

   // command codes
   localparam logic [1:0] OP_MOVE  = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_POINT = 2'd2;

   // stream bytes
   localparam logic [7:0] BYTE_GRAPH = 8'd29;  // enter graph mode
   localparam logic [7:0] BYTE_ALPHA = 8'd31;  // back to alpha mode
   localparam logic [7:0] BYTE_PAD   = 8'd0;
   localparam logic [7:0] BIAS_HI    = 8'd32;
   localparam logic [7:0] BIAS_LO_Y  = 8'd96;
   localparam logic [7:0] BIAS_LO_X  = 8'd64;

   // last byte index per command (10, 12 and 22 bytes)
   localparam logic [IdxWidth-1:0] LAST_MOVE  = 5'd9;
   localparam logic [IdxWidth-1:0] LAST_DRAW  = 5'd11;
   localparam logic [IdxWidth-1:0] LAST_POINT = 5'd21;
   // first byte of the draw half of a point
   localparam logic [IdxWidth-1:0] POINT_DRAW_START = 5'd10;

   // x * 1024 / 2200 == (x * ceil(2^29 / 275)) >> 22, exact for x < 4096
   localparam logic [20:0] SCALE_X_MUL   = 21'd1952258;
   // y * 750 / 3100 == (y * 15 * ceil(2^22 / 62)) >> 22, exact for y < 4096
   localparam logic [19:0] SCALE_Y_MUL   = 20'd1014765;
   localparam int unsigned SCALE_SHIFT   = 22;

   typedef struct packed {
      logic [1:0]            operation;
      logic [CoordWidth-1:0] x_coord;
      logic [CoordWidth-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // one of the four bytes of a coordinate: y high, y low, x high, x low
   function automatic logic [7:0] coord_byte(input logic [TermXWidth-1:0] x,
                                             input logic [TermYWidth-1:0] y,
                                             input logic [1:0]            sel);
      logic [7:0] b;
      case (sel)
         2'd0:    b = {3'b000, y[9:5]} + BIAS_HI;
         2'd1:    b = {3'b000, y[4:0]} + BIAS_LO_Y;
         2'd2:    b = {2'b00, x[10:5]} + BIAS_HI;
         2'd3:    b = {3'b000, x[4:0]} + BIAS_LO_X;
         default: b = BYTE_PAD;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/vtce_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtce_scale: plot to terminal coordinate scaling
// Truncating x*1024/2200 and y*750/3100 by reciprocal multiplication.
// ----------------------------------------------------------------------------
module vtce_scale (
   input  vtce_pkg::req_type                   cmd,
   output logic [vtce_pkg::TermXWidth-1:0]     term_x,
   output logic [vtce_pkg::TermYWidth-1:0]     term_y
);
   import vtce_pkg::*;

   logic [32:0] prod_x;
   logic [31:0] prod_y;

   assign prod_x = 33'(cmd.x_coord) * 33'(SCALE_X_MUL);
   assign prod_y = 32'(cmd.y_coord) * 32'(SCALE_Y_MUL);

   assign term_x = prod_x[SCALE_SHIFT +: TermXWidth];
   assign term_y = prod_y[SCALE_SHIFT +: TermYWidth];

endmodule
`default_nettype wire

// ----- hw/rtl/vector_terminal_coordinate_encoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vector_terminal_coordinate_encoder_top: plot commands to terminal bytes
// Turns move / draw / point commands into a vector-terminal byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one beat per command (operation, x_coord, y_coord).
//    Coordinates are scaled to terminal units, x*1024/2200 and y*750/3100.
//  - rsp channel: one beat per stream byte; last marks the final byte of a
//    command. Move gives 10 beats, draw 12, point 22; code 3 gives none.
//  - Path: a req beat goes through the input register and the serializer
//    to the output register when the serializer is free.
//  - Throughput: one rsp beat per cycle while rsp_stall is low; a new
//    command is loaded in the cycle its predecessor's last byte goes out,
//    with no gap. Code 3 passes through the input register only and
//    never occupies the serializer.
//  - req is stalled only while the input register holds a command that the
//    serializer cannot take yet; one command can wait there.
//  - rsp_stall freezes the output register and the serializer.
//  - Reset (synchronous) empties all stages and sets the pen to (0, 0).
// ----------------------------------------------------------------------------
module vector_terminal_coordinate_encoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vtce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vtce_pkg::rsp_type rsp_data
);
   import vtce_pkg::*;

   // input register
   logic    a_valid_ff, a_valid_in;
   req_type a_req_ff, a_req_in;

   // scaled coordinate of the held command
   logic [TermXWidth-1:0] term_x;
   logic [TermYWidth-1:0] term_y;

   // serializer: command being sent, first (a) and second (b) coordinate
   logic                  busy_ff, busy_in;
   logic [1:0]            op_ff, op_in;
   logic [IdxWidth-1:0]   idx_ff, idx_in;
   logic [TermXWidth-1:0] ax_ff, ax_in, bx_ff, bx_in;
   logic [TermYWidth-1:0] ay_ff, ay_in, by_ff, by_in;

   // pen position
   logic [TermXWidth-1:0] pen_x_ff, pen_x_in;
   logic [TermYWidth-1:0] pen_y_ff, pen_y_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                out_free;
   logic                cmd_last;
   logic                cmd_free;
   logic                a_take;
   logic                draw_phase;
   logic [3:0]          step;
   logic [IdxWidth-1:0] step_full;
   logic [7:0]          byte_val;

   vtce_scale u_scale (
      .cmd    (a_req_ff),
      .term_x (term_x),
      .term_y (term_y)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_free  = !busy_ff || (out_free && cmd_last);
   assign a_take    = a_valid_ff && cmd_free;
   assign req_stall = a_valid_ff && !a_take;

   // end of the current command
   always_comb begin
      case (op_ff)
         OP_MOVE:  cmd_last = busy_ff && (idx_ff == LAST_MOVE);
         OP_DRAW:  cmd_last = busy_ff && (idx_ff == LAST_DRAW);
         OP_POINT: cmd_last = busy_ff && (idx_ff == LAST_POINT);
         default:  cmd_last = 1'b0;
      endcase
   end

   // byte of the current index; a point is a move, then a draw from a to b
   always_comb begin
      if (op_ff == OP_POINT && idx_ff >= POINT_DRAW_START) begin
         draw_phase = 1'b1;
         step_full  = idx_ff - POINT_DRAW_START;
      end else begin
         draw_phase = (op_ff == OP_DRAW);
         step_full  = idx_ff;
      end
      step = step_full[3:0];

      if (step == 4'd0) begin
         byte_val = BYTE_GRAPH;
      end else if (step inside {[4'd1:4'd4]}) begin
         byte_val = coord_byte(ax_ff, ay_ff, 2'(step - 4'd1));
      end else if (draw_phase && (step inside {[4'd5:4'd8]})) begin
         byte_val = coord_byte(bx_ff, by_ff, 2'(step - 4'd5));
      end else if (!draw_phase && step == 4'd5) begin
         byte_val = BYTE_ALPHA;
      end else begin
         byte_val = BYTE_PAD;
      end
   end

   always_comb begin
      a_valid_in   = a_valid_ff && !a_take;
      a_req_in     = a_req_ff;
      busy_in      = busy_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (req_valid && !req_stall) begin
         a_valid_in = 1'b1;
         a_req_in   = req_data;
      end

      // one byte per free output slot
      if (out_free) begin
         rsp_valid_in         = busy_ff;
         rsp_data_in.out_byte = byte_val;
         rsp_data_in.last     = cmd_last;
         if (busy_ff) begin
            idx_in = idx_ff + 1'b1;
            if (cmd_last) begin
               busy_in = 1'b0;
            end
         end
      end

      // load next command; code 3 is dropped here
      if (a_take) begin
         op_in  = a_req_ff.operation;
         idx_in = '0;
         case (a_req_ff.operation)
            OP_MOVE: begin
               busy_in  = 1'b1;
               ax_in    = term_x;
               ay_in    = term_y;
               pen_x_in = term_x;
               pen_y_in = term_y;
            end
            OP_DRAW: begin
               busy_in  = 1'b1;
               ax_in    = pen_x_ff;
               ay_in    = pen_y_ff;
               bx_in    = term_x;
               by_in    = term_y;
               pen_x_in = term_x;
               pen_y_in = term_y;
            end
            OP_POINT: begin
               busy_in  = 1'b1;
               ax_in    = term_x;
               ay_in    = term_y;
               bx_in    = term_x + 1'b1;
               by_in    = term_y;
               pen_x_in = term_x + 1'b1;
               pen_y_in = term_y;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         busy_ff      <= 1'b0;
         op_ff        <= OP_MOVE;
         idx_ff       <= '0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         busy_ff      <= busy_in;
         op_ff        <= op_in;
         idx_ff       <= idx_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff    <= a_req_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/vtce_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtce_checker: port-level checks of the vector terminal encoder
// Watches the handshakes and command framing of the byte stream.
// ----------------------------------------------------------------------------
module vtce_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  vtce_pkg::rsp_type rsp_data
);
   import vtce_pkg::*;

   logic start_ff, start_in;   // next rsp beat opens a command

   always_comb begin
      start_in = start_ff;
      if (rsp_valid && !rsp_stall) begin
         start_in = rsp_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
      end else begin
         start_ff <= start_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   a_cmd_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_ff |-> rsp_data.out_byte == BYTE_GRAPH)
      else $error("command does not open with graph mode byte");

   a_cmd_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.out_byte == BYTE_PAD)
      else $error("command does not end with a pad byte");

endmodule

bind vector_terminal_coordinate_encoder_top vtce_checker u_vtce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ----- verif/vector_terminal_coordinate_encoder_top_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vector_terminal_coordinate_encoder_top_tb: byte stream check of the encoder
// Sends move / draw / point commands, predicts the terminal byte stream of
// each accepted command in a scoreboard, and checks every rsp beat in order.
// ----------------------------------------------------------------------------
module vector_terminal_coordinate_encoder_top_tb;

   import vtce_pkg::*;

   // unused command code, ignored by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // plot to terminal scaling, truncating
   localparam int unsigned X_SCALE_NUM = 1024;
   localparam int unsigned X_SCALE_DEN = 2200;
   localparam int unsigned Y_SCALE_NUM = 750;
   localparam int unsigned Y_SCALE_DEN = 3100;

   localparam int unsigned X_PLOT_MAX = 2199;
   localparam int unsigned Y_PLOT_MAX = 3099;

   localparam int REPORT_LIMIT  = 10;
   localparam int HOLD_CYCLES   = 300;     // long rsp hold-off
   localparam int DRAIN_CYCLES  = 40;      // quiet time after the last byte
   localparam int PHASE_ITEMS   = 120;
   localparam int TIMEOUT_UNITS = 3000000; // watchdog delay in time units

   // -------------------------------------------------------------------------
   // Scoreboard: own pen state, queue of bytes still owed by the block
   // -------------------------------------------------------------------------
   class byte_stream_board;
      logic [TermXWidth-1:0] pen_x;
      logic [TermYWidth-1:0] pen_y;
      rsp_type               owed_bytes[$];
      int                    mismatches;
      int                    beats_seen;

      function new();
         pen_x      = '0;
         pen_y      = '0;
         mismatches = 0;
         beats_seen = 0;
      endfunction

      function void push_byte(logic [7:0] b);
         rsp_type r;
         r.out_byte = b;
         r.last     = 1'b0;
         owed_bytes.push_back(r);
      endfunction

      // y high, y low, x high, x low
      function void push_pen();
         push_byte(8'({3'b000, pen_y[9:5]}) + BIAS_HI);
         push_byte(8'({3'b000, pen_y[4:0]}) + BIAS_LO_Y);
         push_byte(8'({2'b00, pen_x[10:5]}) + BIAS_HI);
         push_byte(8'({3'b000, pen_x[4:0]}) + BIAS_LO_X);
      endfunction

      function void move_to(logic [TermXWidth-1:0] tx, logic [TermYWidth-1:0] ty);
         pen_x = tx;
         pen_y = ty;
         push_byte(BYTE_GRAPH);
         push_pen();
         push_byte(BYTE_ALPHA);
         repeat (4) push_byte(BYTE_PAD);
      endfunction

      // old pen first, then the new one
      function void draw_to(logic [TermXWidth-1:0] tx, logic [TermYWidth-1:0] ty);
         push_byte(BYTE_GRAPH);
         push_pen();
         pen_x = tx;
         pen_y = ty;
         push_pen();
         repeat (3) push_byte(BYTE_PAD);
      endfunction

      function void note_command(req_type cmd);
         int unsigned sx;
         int unsigned sy;
         rsp_type     tail;
         sx = (int'(cmd.x_coord) * X_SCALE_NUM) / X_SCALE_DEN;
         sy = (int'(cmd.y_coord) * Y_SCALE_NUM) / Y_SCALE_DEN;
         case (cmd.operation)
            OP_MOVE: begin
               move_to(sx[TermXWidth-1:0], sy[TermYWidth-1:0]);
            end
            OP_DRAW: begin
               draw_to(sx[TermXWidth-1:0], sy[TermYWidth-1:0]);
            end
            OP_POINT: begin
               // one unit to the right; at the edge this goes to 1024
               move_to(sx[TermXWidth-1:0], sy[TermYWidth-1:0]);
               draw_to(sx[TermXWidth-1:0] + 1'b1, sy[TermYWidth-1:0]);
            end
            default: begin
               return;
            end
         endcase
         tail      = owed_bytes.pop_back();
         tail.last = 1'b1;
         owed_bytes.push_back(tail);
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         beats_seen++;
         if (owed_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: rsp beat %0d unexpected: out_byte %0d last %0b",
                        $time, beats_seen, got.out_byte, got.last);
            return;
         end
         want = owed_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: rsp beat %0d: out_byte exp %0d got %0d, last exp %0b got %0b",
                        $time, beats_seen, want.out_byte, got.out_byte, want.last, got.last);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   vector_terminal_coordinate_encoder_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   byte_stream_board board;

   // per-phase idling, in percent of cycles
   int send_idle_pct;
   int stall_pct;
   bit hold_off_req;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Monitor: both channels sampled at the edge, before any NBA lands.
   // The req beat is noted first; its bytes cannot show up in the same cycle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_command(req_data);
         if (rsp_valid && !rsp_stall)
            board.check_byte(rsp_data);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request so the
   // serializer and the input register both fill and req_stall goes high.
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------

   // Offer one command and hold it until accepted. Valid stays high after
   // the accepting edge; the next call lowers it only if it idles first.
   task automatic send_command(input logic [1:0] op, input logic [11:0] x,
                               input logic [11:0] y);
      req_type cmd;
      cmd.operation = op;
      cmd.x_coord   = x;
      cmd.y_coord   = y;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall);
   endtask

   // extremes get a tenth each, the rest spread over the field or the whole 12-bit range
   function automatic logic [11:0] pick_coord(input int unsigned top);
      int unsigned sel;
      int unsigned v;
      sel = $urandom_range(9);
      case (sel)
         0:       v = 0;
         1:       v = top;
         2:       v = 12'hFFF;
         3:       v = $urandom_range(4095);
         default: v = $urandom_range(top);
      endcase
      return v[11:0];
   endfunction

   // Random commands; ignored code 3 beats do not count toward the phase.
   task automatic run_phase(input int idle_pct, input int stall_p, input int items);
      int          counted;
      logic [1:0]  op;
      counted       = 0;
      send_idle_pct = idle_pct;
      stall_pct     = stall_p;
      while (counted < items) begin
         op = ($urandom_range(99) < 4) ? OP_UNUSED : 2'($urandom_range(2));
         send_command(op, pick_coord(X_PLOT_MAX), pick_coord(Y_PLOT_MAX));
         if (op != OP_UNUSED)
            counted++;
      end
   endtask

   initial begin : stimulus
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_req  = 1'b0;
      board         = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, each command, right edge point,
      // coordinates above the plot range, ignored code between commands.
      send_command(OP_MOVE,   12'd0,    12'd0);
      send_command(OP_DRAW,   12'd2199, 12'd3099);
      send_command(OP_POINT,  12'd2199, 12'd3099);   // tx 1023 -> 1024
      send_command(OP_POINT,  12'd0,    12'd0);
      send_command(OP_MOVE,   12'd4095, 12'd4095);
      send_command(OP_DRAW,   12'd4095, 12'd0);
      send_command(OP_POINT,  12'd4095, 12'd4095);
      send_command(OP_UNUSED, 12'd1234, 12'd2345);   // pen must not move
      send_command(OP_DRAW,   12'd0,    12'd4095);
      send_command(OP_MOVE,   12'd2199, 12'd0);
      send_command(OP_DRAW,   12'd0,    12'd3099);
      send_command(OP_POINT,  12'd2198, 12'd1);
      send_command(OP_DRAW,   12'd2048, 12'd2048);
      send_command(OP_UNUSED, 12'd4095, 12'd4095);
      send_command(OP_MOVE,   12'd1,    12'd1);
      send_command(OP_POINT,  12'd1100, 12'd1550);
      send_command(OP_DRAW,   12'd4095, 12'd4095);

      // Random: long rsp hold-off with a busy sender first, then the
      // idling mixes.
      hold_off_req = 1'b1;
      run_phase(0,  0,  PHASE_ITEMS);
      run_phase(52, 0,  PHASE_ITEMS);
      run_phase(0,  52, PHASE_ITEMS);
      run_phase(16, 16, PHASE_ITEMS);
      req_valid <= 1'b0;

      while (board.owed_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0)
         $display("vector_terminal_coordinate_encoder_top_tb OK");
      else
         $display("vector_terminal_coordinate_encoder_top_tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_UNITS);
      $display("vector_terminal_coordinate_encoder_top_tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire
